// ----- src/look_elevator_scheduler_assert.svh -----
// assertion macros used by the scheduler module
`ifndef LOOK_ELEVATOR_SCHEDULER_ASSERT_SVH
`define LOOK_ELEVATOR_SCHEDULER_ASSERT_SVH

// implication checked every cycle outside reset
`define LES_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication checked outside reset
`define LES_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- src/les_pkg.sv -----
package les_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FLOOR_BITS  = 6;
  localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic       CMD_ADD  = 1'b0;
  localparam logic       CMD_TICK = 1'b1;

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_RIDE = 2'd2;

  localparam logic [1:0] HEAD_IDLE = 2'd0;
  localparam logic [1:0] HEAD_UP   = 2'd1;
  localparam logic [1:0] HEAD_DOWN = 2'd2;

  localparam logic [2:0] EV_DROP   = 3'd0;
  localparam logic [2:0] EV_PICK   = 3'd1;
  localparam logic [2:0] EV_STATUS = 3'd2;
  localparam logic [2:0] EV_ADDED  = 3'd3;
  localparam logic [2:0] EV_FULL   = 3'd4;

  localparam logic CFG_FLOOR_COUNT  = 1'b0;
  localparam logic CFG_CAR_CAPACITY = 1'b1;

  // one request entry
  typedef struct packed {
    logic [7:0]            tag;
    logic [FLOOR_BITS-1:0] origin;
    logic [FLOOR_BITS-1:0] target;
    logic [1:0]            status;
  } entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  shift;   // rotate the ring by one place
    logic                  keep;    // when rotating: keep the head word
    logic                  append;  // load the new entry into the tail
    logic                  drop;    // head rider leaves
    logic                  board;   // head rider boards
  } cell_ctl_t;

endpackage

// ----- src/les_cell.sv -----
// one place of the request ring
module les_cell (
  input  logic             clk,
  input  les_pkg::cell_ctl_t ctl,
  input  logic             is_tail,
  input  logic             is_head,
  input  les_pkg::entry_t  new_entry,
  input  les_pkg::entry_t  from_next,
  output les_pkg::entry_t  word
);
  import les_pkg::*;

  entry_t word_next;

  // load the tail, shift towards the head, or update head status in place
  always_comb begin
    word_next = word;
    if (ctl.append && is_tail) begin
      word_next = new_entry;
    end else if (ctl.shift) begin
      word_next = from_next;
    end else if (is_head && ctl.drop) begin
      word_next.status = ST_DONE;
    end else if (is_head && ctl.board) begin
      word_next.status = ST_RIDE;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end
endmodule

// ----- src/les_chain.sv -----
// ring of cells; the head is cell 0, rotation moves cell i+1 into cell i
module les_chain (
  input  logic                           clk,
  input  les_pkg::cell_ctl_t             ctl,
  input  logic [les_pkg::QIDX_BITS-1:0]  tail_idx,
  input  logic [les_pkg::QIDX_BITS-1:0]  last_idx,
  input  les_pkg::entry_t                new_entry,
  output les_pkg::entry_t                head
);
  import les_pkg::*;

  entry_t words [QUEUE_DEPTH];
  entry_t feed  [QUEUE_DEPTH];

  // the head word goes back behind the last live entry, or is discarded
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      feed[i] = words[(i + 1) % QUEUE_DEPTH];
      if (QIDX_BITS'(i) == last_idx) begin
        feed[i] = ctl.keep ? words[0] : words[i];
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    les_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .is_tail   (QIDX_BITS'(g) == tail_idx),
      .is_head   (g == 0),
      .new_entry (new_entry),
      .from_next (feed[g]),
      .word      (words[g])
    );
  end

  assign head = words[0];
endmodule

// ----- src/look_elevator_scheduler.sv -----
// LOOK elevator scheduler. Requests sit in a ring of 16 cells in arrival
// order and every pass rotates the ring once past its head. An add gives its
// result in the cycle after it is accepted. A tick runs a compaction pass
// (which also finds the first usable heading), a decision step, a drop-off
// pass that pauses at each drop-off, a pick-up pass that pauses at each
// pick-up, and a status step. A tick on an empty store, or one that finds
// no usable heading, answers from the decision step. The result register
// holds one word; while it is stalled the ring waits at the next rider event
// or at the status step. Input is held off from acceptance until the last
// word of that input has been taken. Configuration is to be written while
// idle, which the block does not enforce; it applies from the next tick.
module look_elevator_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid_in,
  output logic       stall_in,
  input  logic       cmd,
  input  logic [7:0] request_tag,
  input  logic [5:0] origin_floor,
  input  logic [5:0] target_floor,
  output logic       valid_out,
  input  logic       stall_out,
  output logic [2:0] event_kind,
  output logic [7:0] event_tag,
  output logic [5:0] car_floor,
  output logic [4:0] car_load,
  output logic [1:0] car_direction,
  output logic       moved,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);
  import les_pkg::*;
  `include "look_elevator_scheduler_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_COMPACT, S_DECIDE, S_DROP, S_BOARD, S_STATUS
  } state_t;

  state_t                state;
  logic [6:0]            floor_count;
  logic [4:0]            car_capacity;
  logic [QCNT_BITS-1:0]  entry_count;
  logic [QCNT_BITS-1:0]  pos;
  logic [FLOOR_BITS-1:0] floor_now;
  logic [1:0]            heading;
  logic [4:0]            riders_inside;
  logic                  pending;
  logic                  ahead;
  logic [1:0]            first_dir;
  logic                  pass_end;
  logic                  tick_done;
  logic                  store_full;
  logic                  stay_idle;
  logic                  out_load;
  logic                  out_valid;
  logic [2:0]            out_kind;
  logic [7:0]            out_tag;
  logic                  out_moved;
  logic                  out_last;
  cell_ctl_t             ctl;
  entry_t                head;
  entry_t                new_entry;
  logic [QIDX_BITS-1:0]  tail_idx;
  logic [QIDX_BITS-1:0]  last_idx;
  logic                  hit_drop;
  logic                  hit_board;
  logic                  head_ahead;
  logic [1:0]            head_dir;
  logic [FLOOR_BITS-1:0] top;
  logic [FLOOR_BITS-1:0] f_head;
  logic [1:0]            plan_dir;
  logic [1:0]            stat_dir;
  logic [FLOOR_BITS-1:0] stat_floor;
  logic                  stat_mv;

  // saturated top floor
  always_comb begin
    if (floor_count < 7'd2) begin
      top = FLOOR_BITS'(1);
    end else if (floor_count > 7'(1 << FLOOR_BITS)) begin
      top = {FLOOR_BITS{1'b1}};
    end else begin
      top = FLOOR_BITS'(floor_count - 7'd1);
    end
  end

  assign new_entry  = '{tag: request_tag, origin: origin_floor, target: target_floor,
                        status: ST_WAIT};
  assign tail_idx   = entry_count[QIDX_BITS-1:0];
  assign last_idx   = QIDX_BITS'(entry_count - QCNT_BITS'(1));
  assign pass_end   = (pos == QCNT_BITS'(1));
  assign store_full = (entry_count == QCNT_BITS'(QUEUE_DEPTH));
  assign hit_drop   = head.status == ST_RIDE && head.target == floor_now;
  assign hit_board  = head.status == ST_WAIT && head.origin == floor_now &&
                      riders_inside < car_capacity;
  assign f_head     = (head.status == ST_WAIT) ? head.origin : head.target;
  assign head_ahead = head.status != ST_DONE &&
                      ((heading == HEAD_UP && f_head > floor_now) ||
                       (heading == HEAD_DOWN && f_head < floor_now));
  assign tick_done  = !out_valid || !stall_out;
  assign stay_idle  = entry_count == '0 || (heading == HEAD_IDLE && first_dir == HEAD_IDLE);

  // heading that the head entry asks for when the car is idle
  always_comb begin
    if (head.origin > floor_now)      head_dir = HEAD_UP;
    else if (head.origin < floor_now) head_dir = HEAD_DOWN;
    else if (head.target > floor_now) head_dir = HEAD_UP;
    else if (head.target < floor_now) head_dir = HEAD_DOWN;
    else                              head_dir = HEAD_IDLE;
  end

  // end of tick: re-plan, turn at the ends, move one floor
  always_comb begin
    plan_dir = heading;
    if (!ahead && riders_inside == '0) begin
      plan_dir = pending ? first_dir : HEAD_IDLE;
    end
    stat_dir = plan_dir;
    if (floor_now >= top && plan_dir == HEAD_UP) begin
      stat_dir = HEAD_DOWN;
    end else if (floor_now == '0 && plan_dir == HEAD_DOWN) begin
      stat_dir = HEAD_UP;
    end
    stat_floor = floor_now;
    stat_mv    = 1'b0;
    if (stat_dir == HEAD_UP && floor_now < top) begin
      stat_floor = floor_now + FLOOR_BITS'(1);
      stat_mv    = 1'b1;
    end else if (stat_dir == HEAD_DOWN && floor_now != '0) begin
      stat_floor = floor_now - FLOOR_BITS'(1);
      stat_mv    = 1'b1;
    end
  end

  // a new word enters the result register
  always_comb begin
    unique case (state)
      S_IDLE:   out_load = valid_in && !stall_in && cmd == CMD_ADD;
      S_DECIDE: out_load = stay_idle;
      S_DROP:   out_load = tick_done && hit_drop;
      S_BOARD:  out_load = tick_done && hit_board;
      S_STATUS: out_load = tick_done;
      default:  out_load = 1'b0;
    endcase
  end

  // cell controls; a rider event holds the ring until its word can be loaded
  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        ctl.append = valid_in && !stall_in && cmd == CMD_ADD && !store_full;
      end
      S_COMPACT: begin
        ctl.shift = 1'b1;
        ctl.keep  = head.status != ST_DONE;
      end
      S_DROP: begin
        ctl.shift = !hit_drop;
        ctl.keep  = 1'b1;
        ctl.drop  = hit_drop && tick_done;
      end
      S_BOARD: begin
        ctl.shift = !hit_board;
        ctl.keep  = 1'b1;
        ctl.board = hit_board && tick_done;
      end
      default: ctl = '0;
    endcase
  end

  les_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .tail_idx  (tail_idx),
    .last_idx  (last_idx),
    .new_entry (new_entry),
    .head      (head)
  );

  assign stall_in = state != S_IDLE || out_valid;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      floor_count   <= 7'd8;
      car_capacity  <= 5'd4;
      entry_count   <= '0;
      floor_now     <= '0;
      heading       <= HEAD_IDLE;
      riders_inside <= '0;
      out_valid     <= 1'b0;
      out_kind      <= '0;
      out_tag       <= '0;
      out_moved     <= 1'b0;
      out_last      <= 1'b0;
      pos           <= '0;
      pending       <= 1'b0;
      ahead         <= 1'b0;
      first_dir     <= HEAD_IDLE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLOOR_COUNT:  floor_count  <= cfg_data;
          CFG_CAR_CAPACITY: car_capacity <= cfg_data[4:0];
        endcase
      end
      out_valid <= out_load || (out_valid && stall_out);
      unique case (state)
        S_IDLE: begin
          if (valid_in && !stall_in) begin
            if (cmd == CMD_ADD) begin
              out_tag   <= request_tag;
              out_moved <= 1'b0;
              out_last  <= 1'b1;
              if (!store_full) begin
                out_kind    <= EV_ADDED;
                entry_count <= entry_count + QCNT_BITS'(1);
              end else begin
                out_kind <= EV_FULL;
              end
            end else begin
              pos       <= entry_count;
              first_dir <= HEAD_IDLE;
              state     <= (entry_count == '0) ? S_DECIDE : S_COMPACT;
            end
          end
        end
        // drop finished entries and look for the first usable heading
        S_COMPACT: begin
          if (head.status == ST_DONE) begin
            entry_count <= entry_count - QCNT_BITS'(1);
          end
          if (first_dir == HEAD_IDLE && head.status == ST_WAIT) begin
            first_dir <= head_dir;
          end
          pos <= pos - QCNT_BITS'(1);
          if (pass_end) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pos <= entry_count;
          if (stay_idle) begin
            heading   <= HEAD_IDLE;
            out_kind  <= EV_STATUS;
            out_tag   <= '0;
            out_moved <= 1'b0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end else begin
            if (heading == HEAD_IDLE) heading <= first_dir;
            state <= S_DROP;
          end
        end
        S_DROP: begin
          if (hit_drop) begin
            if (tick_done) begin
              if (riders_inside != '0) riders_inside <= riders_inside - 5'd1;
              out_kind  <= EV_DROP;
              out_tag   <= head.tag;
              out_moved <= 1'b0;
              out_last  <= 1'b0;
            end
          end else if (pass_end) begin
            pos       <= entry_count;
            pending   <= 1'b0;
            ahead     <= 1'b0;
            first_dir <= HEAD_IDLE;
            state     <= S_BOARD;
          end else begin
            pos <= pos - QCNT_BITS'(1);
          end
        end
        // boarding, and the planning flags from each settled head word
        S_BOARD: begin
          if (hit_board) begin
            if (tick_done) begin
              riders_inside <= riders_inside + 5'd1;
              out_kind      <= EV_PICK;
              out_tag       <= head.tag;
              out_moved     <= 1'b0;
              out_last      <= 1'b0;
            end
          end else begin
            pos     <= pos - QCNT_BITS'(1);
            pending <= pending || head.status != ST_DONE;
            ahead   <= ahead || head_ahead;
            if (first_dir == HEAD_IDLE && head.status == ST_WAIT) begin
              first_dir <= head_dir;
            end
            if (pass_end) begin
              state <= S_STATUS;
            end
          end
        end
        S_STATUS: begin
          if (tick_done) begin
            heading   <= stat_dir;
            floor_now <= stat_floor;
            out_kind  <= EV_STATUS;
            out_tag   <= '0;
            out_moved <= stat_mv;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign valid_out     = out_valid;
  assign event_kind    = out_kind;
  assign event_tag     = out_tag;
  assign car_floor     = floor_now;
  assign car_load      = riders_inside;
  assign car_direction = heading;
  assign moved         = out_moved;
  assign last          = out_last;

  `LES_ASSERT_IMP(a_count_bound, 1'b1, entry_count <= QCNT_BITS'(QUEUE_DEPTH))
  `LES_ASSERT_IMP(a_load_cap, 1'b1, riders_inside <= 5'd16)
  `LES_ASSERT_IMP(a_busy_stalls, state != S_IDLE, stall_in)
  `LES_ASSERT_NXT(a_out_holds, out_valid && stall_out, out_valid && $stable(event_kind))
  `LES_ASSERT_NXT(a_car_holds, out_valid && stall_out, $stable(car_floor) && $stable(car_load))
endmodule

// ----- bench/scheduler_checker.sv -----
module scheduler_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid_in,
  input  logic       stall_in,
  input  logic       cmd,
  input  logic [7:0] request_tag,
  input  logic [5:0] origin_floor,
  input  logic [5:0] target_floor,
  input  logic       valid_out,
  input  logic       stall_out,
  input  logic [2:0] event_kind,
  input  logic [7:0] event_tag,
  input  logic [5:0] car_floor,
  input  logic [4:0] car_load,
  input  logic [1:0] car_direction,
  input  logic       moved,
  input  logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         words_pending
);
  import les_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tag;
    logic [5:0] flr;
    logic [4:0] load;
    logic [1:0] dir;
    logic       mv;
    logic       lst;
  } event_word_t;

  event_word_t expected_events[$];

  // shadow of the car and its request list
  entry_t     list_q[QUEUE_DEPTH];
  int         list_len;
  logic [5:0] car_at;
  logic [1:0] car_dir;
  int         riders;
  logic [6:0] floors_cfg;
  logic [4:0] cap_cfg;

  function automatic void push_event(logic [2:0] k, logic [7:0] t, logic m, logic l);
    event_word_t w;
    w.kind = k; w.tag = t; w.flr = car_at; w.load = riders[4:0];
    w.dir = car_dir; w.mv = m; w.lst = l;
    expected_events.push_back(w);
  endfunction

  function automatic logic any_pending();
    for (int i = 0; i < list_len; i++)
      if (list_q[i].status == ST_WAIT || list_q[i].status == ST_RIDE) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [1:0] first_dir();
    for (int i = 0; i < list_len; i++) begin
      if (list_q[i].status != ST_WAIT) continue;
      if (list_q[i].origin > car_at) return HEAD_UP;
      if (list_q[i].origin < car_at) return HEAD_DOWN;
      if (list_q[i].target > car_at) return HEAD_UP;
      if (list_q[i].target < car_at) return HEAD_DOWN;
    end
    return HEAD_IDLE;
  endfunction

  function automatic logic work_ahead();
    logic [5:0] f;
    for (int i = 0; i < list_len; i++) begin
      if (list_q[i].status == ST_WAIT) f = list_q[i].origin;
      else if (list_q[i].status == ST_RIDE) f = list_q[i].target;
      else continue;
      if (car_dir == HEAD_UP && f > car_at) return 1'b1;
      if (car_dir == HEAD_DOWN && f < car_at) return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected events for one accepted word
  function automatic void predict_word(logic c, logic [7:0] t, logic [5:0] o, logic [5:0] d);
    int w;
    int top;
    logic mv;
    mv = 1'b0;
    if (c == CMD_ADD) begin
      if (list_len >= QUEUE_DEPTH) begin
        push_event(EV_FULL, t, 1'b0, 1'b1);
      end else begin
        list_q[list_len] = '{tag: t, origin: o, target: d, status: ST_WAIT};
        list_len++;
        push_event(EV_ADDED, t, 1'b0, 1'b1);
      end
      return;
    end
    w = 0;
    for (int i = 0; i < list_len; i++)
      if (list_q[i].status != ST_DONE) begin
        list_q[w] = list_q[i];
        w++;
      end
    list_len = w;
    if (!any_pending()) begin
      car_dir = HEAD_IDLE;
      push_event(EV_STATUS, 8'd0, 1'b0, 1'b1);
      return;
    end
    if (car_dir == HEAD_IDLE) begin
      car_dir = first_dir();
      if (car_dir == HEAD_IDLE) begin
        push_event(EV_STATUS, 8'd0, 1'b0, 1'b1);
        return;
      end
    end
    for (int i = 0; i < list_len; i++)
      if (list_q[i].status == ST_RIDE && list_q[i].target == car_at) begin
        list_q[i].status = ST_DONE;
        if (riders > 0) riders--;
        push_event(EV_DROP, list_q[i].tag, 1'b0, 1'b0);
      end
    for (int i = 0; i < list_len; i++)
      if (list_q[i].status == ST_WAIT && list_q[i].origin == car_at && riders < cap_cfg) begin
        list_q[i].status = ST_RIDE;
        riders++;
        push_event(EV_PICK, list_q[i].tag, 1'b0, 1'b0);
      end
    if (!work_ahead() && riders == 0)
      car_dir = any_pending() ? first_dir() : HEAD_IDLE;
    top = floors_cfg;
    if (top < 2) top = 2;
    if (top > (1 << FLOOR_BITS)) top = 1 << FLOOR_BITS;
    top = top - 1;
    if (car_at >= top && car_dir == HEAD_UP) car_dir = HEAD_DOWN;
    else if (car_at == 0 && car_dir == HEAD_DOWN) car_dir = HEAD_UP;
    if (car_dir == HEAD_UP && car_at < top) begin
      car_at++; mv = 1'b1;
    end else if (car_dir == HEAD_DOWN && car_at > 0) begin
      car_at--; mv = 1'b1;
    end
    push_event(EV_STATUS, 8'd0, mv, 1'b1);
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    event_word_t exp_w;
    if (rst) begin
      list_len = 0; car_at = '0; car_dir = HEAD_IDLE; riders = 0;
      floors_cfg <= 7'd8; cap_cfg <= 5'd4; fail_count <= 0;
      expected_events.delete();
      words_pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FLOOR_COUNT) floors_cfg <= cfg_data;
        else cap_cfg <= cfg_data[4:0];
      end
      if (valid_in && !stall_in) predict_word(cmd, request_tag, origin_floor, target_floor);
      if (valid_out && !stall_out) begin
        if (expected_events.size() == 0) begin
          $error("unexpected word kind=%0d tag=%0d", event_kind, event_tag);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_events.pop_front();
          if (exp_w.kind != event_kind || exp_w.tag != event_tag || exp_w.flr != car_floor ||
              exp_w.load != car_load || exp_w.dir != car_direction || exp_w.mv != moved ||
              exp_w.lst != last)
            fail_count <= fail_count + 1;
          if (exp_w.kind != event_kind)
            $error("event_kind exp %0d got %0d", exp_w.kind, event_kind);
          if (exp_w.tag != event_tag)
            $error("event_tag exp %0d got %0d", exp_w.tag, event_tag);
          if (exp_w.flr != car_floor)
            $error("car_floor exp %0d got %0d", exp_w.flr, car_floor);
          if (exp_w.load != car_load)
            $error("car_load exp %0d got %0d", exp_w.load, car_load);
          if (exp_w.dir != car_direction)
            $error("car_direction exp %0d got %0d", exp_w.dir, car_direction);
          if (exp_w.mv != moved)
            $error("moved exp %0d got %0d", exp_w.mv, moved);
          if (exp_w.lst != last)
            $error("last exp %0d got %0d", exp_w.lst, last);
        end
      end
      words_pending <= expected_events.size();
    end
  end
endmodule

// ----- bench/tb.sv -----
module tb;
  import les_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk, rst;
  logic       valid_in, stall_in, cmd;
  logic [7:0] request_tag;
  logic [5:0] origin_floor, target_floor;
  logic       valid_out, stall_out;
  logic [2:0] event_kind;
  logic [7:0] event_tag;
  logic [5:0] car_floor;
  logic [4:0] car_load;
  logic [1:0] car_direction;
  logic       moved, last;
  logic       cfg_we, cfg_index;
  logic [6:0] cfg_data;
  int         fail_count, words_pending;
  int         cycle_count = 0;

  look_elevator_scheduler u_top (.*);
  scheduler_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver stalls at random, with calm stretches
  initial begin
    int gap;
    stall_out = 1'b0;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (($urandom_range(0, 99) < 30)) gap = 0;
      stall_out = (gap != 0);
      repeat (gap) @(negedge clk);
      stall_out = 1'b0;
      @(negedge clk);
    end
  end

  // stall_in only changes at the rising edge, so it is looked at on the falling one
  task automatic send_word(logic c, logic [7:0] t, logic [5:0] o, logic [5:0] d, bit hurry);
    int gap;
    gap = hurry ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    valid_in = 1'b1; cmd = c; request_tag = t; origin_floor = o; target_floor = d;
    while (stall_in) @(negedge clk);
    @(negedge clk);
    valid_in = 1'b0;
  endtask

  task automatic wait_drained();
    while (words_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_req(logic [7:0] t, logic [5:0] o, logic [5:0] d);
    send_word(CMD_ADD, t, o, d, 1'b0);
  endtask

  task automatic tick_n(int n);
    repeat (n) send_word(CMD_TICK, 8'($urandom), 6'($urandom), 6'($urandom),
                         $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int nf;
    valid_in = 1'b0; cmd = CMD_ADD; request_tag = '0; origin_floor = '0; target_floor = '0;
    cfg_we = 1'b0; cfg_index = CFG_FLOOR_COUNT; cfg_data = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty tick, riders at the same floor, extremes
    tick_n(1);
    add_req(8'd0, 6'd0, 6'd0);
    tick_n(1);
    add_req(8'hFF, 6'd63, 6'd63);
    add_req(8'h5A, 6'd0, 6'd7);
    add_req(8'hA5, 6'd7, 6'd0);
    tick_n(12);
    // fill the store to overflow
    for (int i = 0; i < 18; i++) add_req(i[7:0], 6'd3, 6'd5);
    tick_n(4);
    wait_drained();

    // capacity zero then the extremes of both registers
    write_reg(CFG_CAR_CAPACITY, 7'd0);
    write_reg(CFG_FLOOR_COUNT, 7'd0);
    tick_n(6);
    wait_drained();
    write_reg(CFG_FLOOR_COUNT, 7'd127);
    write_reg(CFG_CAR_CAPACITY, 7'd31);
    tick_n(4);
    wait_drained();

    // random phases under several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin nf = 64; write_reg(CFG_CAR_CAPACITY, 7'd16); end
        1: begin nf = 2; write_reg(CFG_CAR_CAPACITY, 7'd1); end
        2: begin nf = 5; write_reg(CFG_CAR_CAPACITY, 7'd2); end
        default: begin
          nf = $urandom_range(2, 12);
          write_reg(CFG_CAR_CAPACITY, 7'($urandom_range(0, 16)));
        end
      endcase
      write_reg(CFG_FLOOR_COUNT, nf[6:0]);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 99) < 45) begin
          // mostly floors in range, some beyond the top
          if ($urandom_range(0, 9) == 0)
            add_req(8'($urandom), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
          else
            add_req(8'($urandom), 6'($urandom_range(0, nf - 1)),
                    6'($urandom_range(0, nf - 1)));
        end else begin
          tick_n(1);
        end
      end
      wait_drained();
    end

    wait_drained();
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/les_pkg.sv
src/les_cell.sv
src/les_chain.sv
src/look_elevator_scheduler.sv
bench/scheduler_checker.sv
bench/tb.sv
